FILE: hdl/ipv4r_pkg.sv
package ipv4r_pkg;

  // Lookahead window
  localparam int WIN_DEPTH = 16;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int WIN_CW    = $clog2(WIN_DEPTH + 1);

  // Dotted-quad grammar
  localparam int GROUPS       = 4;
  localparam int GRP_W        = $clog2(GROUPS);
  localparam int GROUP_DIGITS = 3;
  localparam int DIG_W        = $clog2(GROUP_DIGITS + 1);
  localparam int OCTET_MAX    = 255;
  localparam int VAL_W        = 10;  // holds up to 999

  // Replacement text
  localparam int REDACT_LEN = 10;
  localparam int IDX_W      = $clog2(REDACT_LEN);

  localparam logic [7:0] ASCII_DOT  = 8'h2E;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  // Default queue depths
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF   = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_dig;
    logic       is_dot;
    logic       last;
  } cls_item_t;

  typedef enum logic {
    BK_RUN,
    BK_REDACT
  } bk_state_t;

  // Back-end status, watched at the top level
  typedef struct packed {
    logic [WIN_CW-1:0] win_cnt;
    logic              msg_end;
    logic              redacting;
  } bk_stat_t;

  function automatic logic [7:0] redact_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h5B;  // [
      4'd1:    c = 8'h52;  // R
      4'd2:    c = 8'h45;  // E
      4'd3:    c = 8'h44;  // D
      4'd4:    c = 8'h41;  // A
      4'd5:    c = 8'h43;  // C
      4'd6:    c = 8'h54;  // T
      4'd7:    c = 8'h45;  // E
      4'd8:    c = 8'h44;  // D
      4'd9:    c = 8'h5D;  // ]
      default: c = 8'h5D;
    endcase
    return c;
  endfunction

  function automatic cls_item_t classify(input in_item_t it);
    cls_item_t r;
    r.data   = it.in_byte;
    r.is_dig = (it.in_byte >= ASCII_ZERO) && (it.in_byte <= ASCII_NINE);
    r.is_dot = (it.in_byte == ASCII_DOT);
    r.last   = it.in_last;
    return r;
  endfunction

endpackage

FILE: hdl/ipv4r_fifo.sv
module ipv4r_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: hdl/ipv4r_front.sv
module ipv4r_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  ipv4r_pkg::in_item_t   in_item,
  output logic                  q_push,
  output ipv4r_pkg::cls_item_t  q_item,
  input  logic                  q_full
);
  import ipv4r_pkg::*;

  logic      valid_r, valid_nxt;
  cls_item_t item_r, item_nxt;
  logic      accept;

  // Holding stage; drains into the queue whenever it has room
  assign full   = valid_r && q_full;
  assign accept = push && !full;
  assign q_push = valid_r;
  assign q_item = item_r;

  always_comb begin
    valid_nxt = valid_r && q_full;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt = 1'b1;
      item_nxt  = classify(in_item);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

FILE: hdl/ipv4r_back.sv
module ipv4r_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipv4r_pkg::cls_item_t  q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_push,
  output ipv4r_pkg::out_item_t  out_wdata,
  input  logic                  out_full,
  output ipv4r_pkg::bk_stat_t   stat
);
  import ipv4r_pkg::*;

  cls_item_t         win_r [WIN_DEPTH];
  logic [WIN_AW-1:0] head_r, head_nxt;
  logic [WIN_CW-1:0] cnt_r, cnt_nxt;
  logic [WIN_CW-1:0] sp_r, sp_nxt;      // bytes of the window already parsed
  logic              end_r, end_nxt;    // last byte of message is in the window
  logic [GRP_W-1:0]  grp_r, grp_nxt;
  logic [DIG_W-1:0]  dig_r, dig_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [7:0]        front_r, front_nxt;
  bk_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              red_last_r, red_last_nxt;

  cls_item_t         cur;
  logic              have, from_q, win_we;
  logic [WIN_AW-1:0] rd_idx, tail;
  logic [WIN_CW-1:0] cnt_tmp, drop;
  logic              end_after;
  logic [VAL_W-1:0]  val_mul;
  logic [DIG_W-1:0]  dig_inc;
  logic              fail, match;
  logic [7:0]        fail_byte;

  assign stat.win_cnt   = cnt_r;
  assign stat.msg_end   = end_r;
  assign stat.redacting = (state_r == BK_REDACT);

  assign rd_idx  = head_r + sp_r[WIN_AW-1:0];
  assign tail    = head_r + cnt_r[WIN_AW-1:0];
  assign val_mul = VAL_W'({val_r, 3'b000}) + VAL_W'({val_r, 1'b0})
                 + VAL_W'(cur.data[3:0]);
  assign dig_inc = dig_r + DIG_W'(1);

  always_comb begin
    // byte source: rescan from the window first, then fresh bytes
    have   = 1'b0;
    from_q = 1'b0;
    cur    = q_head;
    if (sp_r < cnt_r) begin
      have = 1'b1;
      cur  = win_r[rd_idx];
    end else if (!end_r && !q_empty) begin
      have   = 1'b1;
      from_q = 1'b1;
    end
  end

  always_comb begin
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    sp_nxt       = sp_r;
    end_nxt      = end_r;
    grp_nxt      = grp_r;
    dig_nxt      = dig_r;
    val_nxt      = val_r;
    front_nxt    = front_r;
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    red_last_nxt = red_last_r;
    q_pop        = 1'b0;
    win_we       = 1'b0;
    out_push     = 1'b0;
    out_wdata    = '0;
    fail         = 1'b0;
    match        = 1'b0;
    drop         = sp_r;
    cnt_tmp      = cnt_r + WIN_CW'(from_q);
    end_after    = end_r || (from_q && cur.last);
    fail_byte    = (sp_r == '0) ? cur.data : front_r;

    unique case (state_r)
      BK_RUN: begin
        if (!out_full) begin
          if (have) begin
            if (from_q) begin
              q_pop   = 1'b1;
              win_we  = 1'b1;
              cnt_nxt = cnt_tmp;
              end_nxt = end_after;
            end
            if (dig_r == '0) begin
              // start of a group: a digit is required
              if (cur.is_dig) begin
                dig_nxt = DIG_W'(1);
                val_nxt = VAL_W'(cur.data[3:0]);
              end else begin
                fail = 1'b1;
              end
            end else if (cur.is_dig) begin
              if (dig_r == DIG_W'(GROUP_DIGITS)) begin
                fail = 1'b1;
              end else if (dig_inc == DIG_W'(GROUP_DIGITS)
                           && val_mul > VAL_W'(OCTET_MAX)) begin
                fail = 1'b1;
              end else begin
                dig_nxt = dig_inc;
                val_nxt = val_mul;
              end
            end else if (grp_r != GRP_W'(GROUPS - 1)) begin
              if (cur.is_dot) begin
                grp_nxt = grp_r + GRP_W'(1);
                dig_nxt = '0;
              end else begin
                fail = 1'b1;
              end
            end else if (cur.is_dot) begin
              fail = 1'b1;
            end else begin
              match = 1'b1;   // terminator stays in the window
            end
            if (!fail && !match) begin
              sp_nxt = sp_r + WIN_CW'(1);
              if (sp_r == '0) begin
                front_nxt = cur.data;
              end
            end
          end else if (end_r) begin
            if (cnt_r == '0) begin
              end_nxt = 1'b0;
            end else if (dig_r != '0 && grp_r == GRP_W'(GROUPS - 1)) begin
              match = 1'b1;
              drop  = cnt_r;
            end else begin
              fail = 1'b1;
            end
          end
        end
      end

      BK_REDACT: begin
        if (!out_full) begin
          out_push           = 1'b1;
          out_wdata.out_byte = redact_char(idx_r);
          out_wdata.out_last = red_last_r && (idx_r == IDX_W'(REDACT_LEN - 1));
          idx_nxt            = idx_r + IDX_W'(1);
          if (idx_r == IDX_W'(REDACT_LEN - 1)) begin
            state_nxt = BK_RUN;
          end
        end
      end

      default: state_nxt = BK_RUN;
    endcase

    if (fail) begin
      out_push           = 1'b1;
      out_wdata.out_byte = fail_byte;
      out_wdata.out_last = end_after && (cnt_tmp == WIN_CW'(1));
      head_nxt           = head_r + WIN_AW'(1);
      cnt_nxt            = cnt_tmp - WIN_CW'(1);
    end
    if (match) begin
      head_nxt     = head_r + drop[WIN_AW-1:0];
      cnt_nxt      = cnt_tmp - drop;
      state_nxt    = BK_REDACT;
      idx_nxt      = '0;
      red_last_nxt = end_after && (cnt_tmp == drop);
    end
    if (fail || match) begin
      sp_nxt  = '0;
      grp_nxt = '0;
      dig_nxt = '0;
      val_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      cnt_r      <= '0;
      sp_r       <= '0;
      end_r      <= 1'b0;
      grp_r      <= '0;
      dig_r      <= '0;
      val_r      <= '0;
      state_r    <= BK_RUN;
      idx_r      <= '0;
      red_last_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      cnt_r      <= cnt_nxt;
      sp_r       <= sp_nxt;
      end_r      <= end_nxt;
      grp_r      <= grp_nxt;
      dig_r      <= dig_nxt;
      val_r      <= val_nxt;
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      red_last_r <= red_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    if (win_we) begin
      win_r[tail] <= cur;
    end
  end

endmodule

FILE: hdl/ipv4_address_redactor_top.sv
// IPv4 address redactor.
// Input channel: push/full with in_item {in_byte, in_last}; a transaction
// completes on a clock edge with push high and full low. in_last marks the
// final byte of a message.
// Result channel: empty/pop with out_item {out_byte, out_last}; the oldest
// result sits on out_item while empty is low and leaves on an edge with pop
// high. out_last marks the final output byte of a message.
// Every dotted-quad address is replaced by the ten bytes [REDACTED].
// A byte is registered in the front register, written into the internal
// queue, parsed by the back engine straight from the queue head, and a result
// decided there is written into the output queue, whose head shows on out_item.
// Bytes of a candidate wait in the 16-byte window until the following byte
// decides. Throughput: one plain byte per cycle while the output queue has
// room; a match is decided, then the ten replacement bytes go out; a failed
// candidate of k bytes re-parses its k-1 trailing bytes from the window,
// one per cycle while the output queue has room. The back engine's single
// parse step sets these rates. An idle step closes each message.
// Reset (rst_n low, synchronous) empties all queues and the window.
// When the receiver stalls, the output queue fills, the engine holds, then
// the internal queue and finally full rises; nothing is dropped.
module ipv4_address_redactor_top #(
  parameter int QUEUE_DEPTH = ipv4r_pkg::QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = ipv4r_pkg::OUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  ipv4r_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output ipv4r_pkg::out_item_t out_item
);
  import ipv4r_pkg::*;

  // front -> queue
  logic      fq_push, fq_full;
  cls_item_t fq_item;
  // queue -> back
  logic      q_pop, q_empty;
  cls_item_t q_head;
  logic [$bits(cls_item_t)-1:0] q_rdata;
  // back -> output queue
  logic      out_push, out_full;
  out_item_t out_wdata;
  logic [$bits(out_item_t)-1:0] out_rdata;
  bk_stat_t  bk_stat;

  // Front: accepts transactions and classifies each byte
  ipv4r_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_push  (fq_push),
    .q_item  (fq_item),
    .q_full  (fq_full)
  );

  // Decoupling queue between classification and the window engine
  ipv4r_fifo #(
    .WIDTH ($bits(cls_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_item),
    .full  (fq_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_head = cls_item_t'(q_rdata);

  // Back: lookahead window, incremental parser, replacement sequencer
  ipv4r_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_push  (out_push),
    .out_wdata (out_wdata),
    .out_full  (out_full),
    .stat      (bk_stat)
  );

  // Output queue: keeps the engine running while a result waits
  ipv4r_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_item = out_item_t'(out_rdata);

  // Engine never writes a result the output queue cannot take
  a_no_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result written into full output queue");

  // Engine never takes a byte that is not there
  a_no_q_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty internal queue");

  // Lookahead never exceeds the window
  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.win_cnt <= WIN_CW'(WIN_DEPTH))
    else $error("window count beyond depth");

  // No new byte is parsed while the replacement text is going out
  a_redact_hold: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.redacting |-> !q_pop)
    else $error("byte taken during replacement output");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result pending after reset");

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import ipv4r_pkg::*;

  // Scan outcome for the candidate at the front of the window
  typedef enum int {
    SCAN_FAIL,
    SCAN_MATCH,
    SCAN_WAIT
  } scan_verdict_t;

  // Handshake idling pattern for one phase of the run
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  localparam int                      MAX_STEP_RESULTS = 32;
  localparam logic [8*REDACT_LEN-1:0] REDACT_TEXT      = "[REDACTED]";
  localparam int                      PHASE_ITEMS      = 80;
  localparam int                      TAIL_CYCLES      = 40;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  // Set at a rising edge when the item on in_item was taken by the block
  logic      in_taken = 1'b0;

  in_item_t   byte_feed_q[$];   // items waiting for the driver
  out_item_t  redacted_q[$];    // predicted output bytes, oldest first
  logic [7:0] msg_bytes[$];     // message under construction
  logic [7:0] win_q[WIN_DEPTH]; // predictor's copy of the lookahead window
  int         win_cnt      = 0;
  int         step_results = 0;
  int         mismatch_cnt = 0;
  int         items_queued = 0;
  idle_mode_t idle_mode    = IDLE_NONE;

  ipv4_address_redactor_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  // ---------------------------------------------------------------------
  // Clock and limit
  // ---------------------------------------------------------------------
  initial begin
    forever #6 clk = ~clk;
  end

  // Far beyond the slowest legal run, even with every receiver stall
  initial begin
    #48_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic bit is_digit(input logic [7:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  // Decides the candidate that starts at the window front. len returns the
  // number of bytes covered by a match.
  function automatic scan_verdict_t scan_quad(input int cnt, input bit at_end,
                                              output int len);
    int pos;
    int val;
    int nd;
    pos = 0;
    len = 0;
    for (int g = 0; g < GROUPS; g++) begin
      val = 0;
      nd  = 0;
      if (pos >= cnt) begin
        if (at_end) return SCAN_FAIL;
        return SCAN_WAIT;
      end
      if (!is_digit(win_q[pos])) return SCAN_FAIL;
      while (pos < cnt && is_digit(win_q[pos])) begin
        if (nd == GROUP_DIGITS) return SCAN_FAIL;
        val = val * 10 + int'(win_q[pos] - ASCII_ZERO);
        nd++;
        pos++;
      end
      if (val > OCTET_MAX) return SCAN_FAIL;
      if (pos >= cnt && !at_end) return SCAN_WAIT;
      if (g < GROUPS - 1) begin
        if (pos >= cnt || win_q[pos] != ASCII_DOT) return SCAN_FAIL;
        pos++;
      end
    end
    // a trailing dot or digit spoils the match
    if (pos < cnt && (win_q[pos] == ASCII_DOT || is_digit(win_q[pos])))
      return SCAN_FAIL;
    len = pos;
    return SCAN_MATCH;
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    out_item_t r;
    if (step_results < MAX_STEP_RESULTS) begin
      r.out_byte = b;
      r.out_last = 1'b0;
      redacted_q = {redacted_q, r};
      step_results++;
    end
  endtask

  task automatic drop_front(input int k);
    if (k > win_cnt) k = win_cnt;
    for (int i = 0; i + k < win_cnt; i++) win_q[i] = win_q[i + k];
    win_cnt -= k;
  endtask

  task automatic redact_predict(input in_item_t it);
    int            len;
    scan_verdict_t verdict;
    out_item_t     r;
    step_results = 0;
    if (win_cnt >= WIN_DEPTH) begin
      emit_byte(win_q[0]);
      drop_front(1);
    end
    win_q[win_cnt] = it.in_byte;
    win_cnt++;
    while (win_cnt > 0) begin
      verdict = scan_quad(win_cnt, it.in_last, len);
      if (verdict == SCAN_WAIT) break;
      if (verdict == SCAN_MATCH && len > 0) begin
        for (int i = 0; i < REDACT_LEN; i++)
          emit_byte(REDACT_TEXT[8*(REDACT_LEN-1-i) +: 8]);
        drop_front(len);
      end else begin
        emit_byte(win_q[0]);
        drop_front(1);
      end
    end
    if (it.in_last) begin
      win_cnt = 0;
      if (step_results > 0) begin
        r = redacted_q.pop_back();
        r.out_last = 1'b1;
        redacted_q = {redacted_q, r};
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------
  // Idling: at most one draw per cycle and side
  // ---------------------------------------------------------------------
  function automatic bit idle_now(input bit sender);
    int pct;
    case (idle_mode)
      IDLE_SEND: pct = sender ? 87 : 0;
      IDLE_RECV: pct = sender ? 0 : 87;
      IDLE_BOTH: pct = 29;
      default:   pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: inputs change on the falling edge only
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      // a held transaction stays on the port until the block takes it
      if (!push || in_taken) begin
        if (byte_feed_q.size() != 0 && !idle_now(1'b1)) begin
          in_item <= byte_feed_q.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= !idle_now(1'b0);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: both channels sampled on the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      if (push && !full) redact_predict(in_item);
      if (pop && !empty) begin
        if (redacted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %h last %b",
                                    out_item.out_byte, out_item.out_last));
        end else begin
          exp_r = redacted_q.pop_front();
          if (out_item.out_byte !== exp_r.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      out_item.out_byte, exp_r.out_byte));
          if (out_item.out_last !== exp_r.out_last)
            report_mismatch($sformatf("out_last %b, expected %b (byte %h)",
                                      out_item.out_last, exp_r.out_last,
                                      exp_r.out_byte));
        end
      end
    end
    in_taken <= rst_n && push && !full;
  end

  // ---------------------------------------------------------------------
  // Message builders
  // ---------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Turns msg_bytes into transactions, in_last on the final byte
  task automatic send_message();
    in_item_t it;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      it.in_byte  = msg_bytes[i];
      it.in_last  = (i == msg_bytes.size() - 1);
      byte_feed_q = {byte_feed_q, it};
    end
    items_queued += msg_bytes.size();
    msg_bytes.delete();
  endtask

  // One decimal group; mostly legal octets, now and then above 255 or
  // padded with leading zeros
  task automatic add_group();
    int         v;
    int         nd;
    int         w;
    logic [7:0] dg[3];
    if ($urandom_range(0, 5) == 0) v = $urandom_range(256, 999);
    else v = $urandom_range(0, 255);
    nd = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
    w  = ($urandom_range(0, 3) == 0) ? $urandom_range(nd, 3) : nd;
    dg[0] = ASCII_ZERO + 8'(v / 100);
    dg[1] = ASCII_ZERO + 8'((v / 10) % 10);
    dg[2] = ASCII_ZERO + 8'(v % 10);
    for (int i = 3 - w; i < 3; i++) add_byte(dg[i]);
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 5))
      0: add_byte(ASCII_ZERO + 8'($urandom_range(0, 9)));
      1: add_byte(ASCII_DOT);
      2: add_byte(8'h20);
      3: add_byte(8'h61 + 8'($urandom_range(0, 25)));
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Four groups joined by dots; some get one token dropped
  task automatic add_quad();
    int skip;
    skip = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 6) : 7;
    for (int t = 0; t < 7; t++) begin
      if (t != skip) begin
        if (t % 2 == 0) add_group();
        else add_byte(ASCII_DOT);
      end
    end
  endtask

  task automatic build_random_message();
    int nseg;
    nseg = $urandom_range(1, 3);
    for (int s = 0; s < nseg; s++) begin
      if ($urandom_range(0, 99) < 70) add_quad();
      else repeat ($urandom_range(1, 4)) add_noise();
      if ($urandom_range(0, 99) < 60) add_noise();
    end
    send_message();
  endtask

  // Holds the sender off until every predicted byte has come out
  task automatic drain();
    while (byte_feed_q.size() != 0 || push || redacted_q.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    idle_mode_t phase_mode[5];
    phase_mode = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: a fourth group that closes the message
    add_text("1.2.3.4");
    send_message();
    // candidate inside a digit run, a group above 255, then a match
    add_text("1256.0.0.9x");
    send_message();
    // quad followed by a dot is no match; scanning restarts one byte on
    add_text("7.8.9.1.2");
    send_message();
    // all-zero and all-one bytes, then a candidate cut off by the end
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("1.2");
    send_message();
    drain();

    // random phases, each closed by a full drain
    foreach (phase_mode[p]) begin
      idle_mode    = phase_mode[p];
      items_queued = 0;
      while (items_queued < PHASE_ITEMS) build_random_message();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (redacted_q.size() != 0)
      report_mismatch($sformatf("%0d output bytes never arrived", redacted_q.size()));

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: ipv4_address_redactor_top.f
hdl/ipv4r_pkg.sv
hdl/ipv4r_fifo.sv
hdl/ipv4r_front.sv
hdl/ipv4r_back.sv
hdl/ipv4_address_redactor_top.sv
bench/tb_top.sv
